[src/geodetic_to_ecef_converter_assert.svh]
// assertion macros for the geodetic to ecef converter
`ifndef GEODETIC_TO_ECEF_CONVERTER_ASSERT_SVH
`define GEODETIC_TO_ECEF_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GTEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtec assertion failed");

`define GTEC_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gtec reset assertion failed");

`else

`define GTEC_ASSERT(lbl, clk, rst_n, prop)

`define GTEC_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

[src/gtec_pkg.sv]
`timescale 1ns / 1ps

package gtec_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int MAX_STAGES   = 48;
    localparam int ST = (CORDIC_STEPS > MAX_STAGES) ? MAX_STAGES : CORDIC_STEPS;
    localparam int INV_ITERS = 12;
    localparam int NSTEP = 3 * INV_ITERS + 8;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] E2_NUM  = 64'd669437999013;
    localparam logic [63:0] E2_DEN  = 64'd100000000000000;
    localparam logic [63:0] A_MM    = 64'd6378137000;
    localparam logic [63:0] OUT_LIMIT = 64'd6500000000;
    localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
    localparam logic [63:0] HALF_Q62  = 64'h2000000000000000;
    localparam logic [63:0] THREE_Q62 = 64'hC000000000000000;

    typedef enum logic [3:0] {
        K_SQ, K_E2, K_RR, K_VT, K_RU, K_N, K_NZ, K_RC, K_X, K_Y, K_Z
    } step_kind_t;

    typedef struct packed {
        logic               valid;
        logic signed [63:0] slat;
        logic signed [63:0] clat;
        logic signed [63:0] slon;
        logic signed [63:0] clon;
        logic signed [63:0] h;
        logic signed [63:0] rr;
        logic signed [63:0] zz;
        logic signed [63:0] rc;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic [63:0]        v;
        logic [63:0]        r;
        logic [63:0]        t;
        logic [63:0]        n;
    } job_t;

    // elaboration-time helpers
    function automatic logic [63:0] mul_shr_c(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic logic [63:0] udiv_c(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        int k;
        rem = '0;
        q = '0;
        for (k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            q = q << 1;
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] invsqrt_c(input logic [63:0] v);
        logic [63:0] r, r2, t, u;
        int k;
        r = HALF_Q62;
        for (k = 0; k < INV_ITERS; k++) begin
            r2 = mul_shr_c(r, r, 62);
            t = mul_shr_c(v, r2, 62);
            u = THREE_Q62 - t;
            r = mul_shr_c(r, u, 63);
        end
        return r;
    endfunction

    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] sum, term;
        logic [127:0] p;
        int k;
        sum = '0;
        if (i == 0) begin
            return 64'd1 << 45;
        end
        for (k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) < 64) begin
                term = udiv_c(64'd1 << (64 - i * (2 * k + 1)), 64'(2 * k + 1));
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
        end
        p = {64'd0, sum} * {64'd0, INV_TWO_PI_Q64};
        return (p[127:64] + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] cordic_gain();
        logic [63:0] p;
        int i;
        p = ONE_Q62;
        for (i = 0; i < MAX_STAGES; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        return invsqrt_c(p);
    endfunction

    function automatic logic [63:0] e2_q62_c();
        logic [63:0] rem, q;
        int k;
        rem = E2_NUM;
        q = '0;
        for (k = 0; k < 63; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= E2_DEN) begin
                rem = rem - E2_DEN;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    localparam logic [63:0] GAIN_Q62 = cordic_gain();
    localparam logic [63:0] X_INIT   = GAIN_Q62 >> 2;
    localparam logic [63:0] E2_Q62   = e2_q62_c();
    localparam logic [63:0] ONE_M_E2 = ONE_Q62 - E2_Q62;

    function automatic step_kind_t step_kind(input int g);
        step_kind_t k;
        if (g == 0) begin
            k = K_SQ;
        end else if (g == 1) begin
            k = K_E2;
        end else if (g < 2 + 3 * INV_ITERS) begin
            if ((g - 2) % 3 == 0) begin
                k = K_RR;
            end else if ((g - 2) % 3 == 1) begin
                k = K_VT;
            end else begin
                k = K_RU;
            end
        end else if (g == 2 + 3 * INV_ITERS) begin
            k = K_N;
        end else if (g == 3 + 3 * INV_ITERS) begin
            k = K_NZ;
        end else if (g == 4 + 3 * INV_ITERS) begin
            k = K_RC;
        end else if (g == 5 + 3 * INV_ITERS) begin
            k = K_X;
        end else if (g == 6 + 3 * INV_ITERS) begin
            k = K_Y;
        end else begin
            k = K_Z;
        end
        return k;
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] apply_sign(input logic neg, input logic [63:0] m);
        return neg ? -signed'(m) : signed'(m);
    endfunction

    function automatic logic [63:0] op_a(input step_kind_t k, input job_t j);
        logic [63:0] a;
        case (k)
            K_SQ:    a = mag(j.slat);
            K_E2:    a = E2_Q62;
            K_RR:    a = j.r;
            K_VT:    a = j.v;
            K_RU:    a = j.r;
            K_N:     a = A_MM;
            K_NZ:    a = j.n;
            K_RC:    a = mag(j.rr);
            K_X:     a = mag(j.rc);
            K_Y:     a = mag(j.rc);
            K_Z:     a = mag(j.zz);
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [63:0] op_b(input step_kind_t k, input job_t j);
        logic [63:0] b;
        case (k)
            K_SQ:    b = mag(j.slat);
            K_E2:    b = j.t;
            K_RR:    b = j.r;
            K_VT:    b = j.t;
            K_RU:    b = j.t;
            K_N:     b = j.r;
            K_NZ:    b = ONE_M_E2;
            K_RC:    b = mag(j.clat);
            K_X:     b = mag(j.clon);
            K_Y:     b = mag(j.slon);
            K_Z:     b = mag(j.slat);
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic job_t post(input step_kind_t k, input job_t ji, input logic [127:0] p);
        job_t j;
        j = ji;
        case (k)
            K_SQ: j.t = p[121:58];
            K_E2: begin
                j.v = ONE_Q62 - p[125:62];
                j.r = HALF_Q62;
            end
            K_RR: j.t = p[125:62];
            K_VT: j.t = THREE_Q62 - p[125:62];
            K_RU: j.r = p[126:63];
            K_N:  j.n = p[105:42];
            K_NZ: begin
                j.rr = signed'(j.n) + j.h;
                j.zz = signed'(p[125:62]) + j.h;
            end
            K_RC:    j.rc = apply_sign(j.rr[63] ^ j.clat[63], p[123:60]);
            K_X:     j.x = apply_sign(j.rc[63] ^ j.clon[63], p[123:60]);
            K_Y:     j.y = apply_sign(j.rc[63] ^ j.slon[63], p[123:60]);
            K_Z:     j.z = apply_sign(j.zz[63] ^ j.slat[63], p[123:60]);
            default: j.t = ji.t;
        endcase
        return j;
    endfunction

    function automatic logic [33:0] finish(input logic signed [63:0] q);
        logic [63:0] m;
        m = (mag(q) + 64'd524288) >> 20;
        if (m > OUT_LIMIT) begin
            m = OUT_LIMIT;
        end
        if (q[63]) begin
            m = -m;
        end
        return m[33:0];
    endfunction

endpackage

[src/gtec_cordic.sv]
`timescale 1ns / 1ps

module gtec_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [31:0]  angle,
    output logic                out_valid,
    output logic signed [63:0]  out_x,
    output logic signed [63:0]  out_y,
    output logic                out_flip
);
    import gtec_pkg::*;

    logic               valid_reg [0:ST];
    logic signed [63:0] x_reg [0:ST];
    logic signed [63:0] y_reg [0:ST];
    logic signed [63:0] z_reg [0:ST];
    logic               flip_reg [0:ST];

    logic signed [32:0] a_ext, a_fold;
    logic               flip_next;

    // fold into +-90 degrees
    always_comb begin
        a_ext = {angle[31], angle};
        a_fold = a_ext;
        flip_next = 1'b0;
        if (a_ext > 33'sd1073741824) begin
            a_fold = a_ext - 33'sd2147483648;
            flip_next = 1'b1;
        end else if (a_ext < -33'sd1073741824) begin
            a_fold = a_ext + 33'sd2147483648;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= signed'(X_INIT);
            y_reg[0]    <= '0;
            z_reg[0]    <= {{15{a_fold[32]}}, a_fold, 16'd0};
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < ST; i++) begin : g_stage
        localparam logic [63:0] ATAN_I = atan_entry(i);
        logic signed [63:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][63]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - signed'(ATAN_I);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + signed'(ATAN_I);
                end
            end
        end
    end

    assign out_valid = valid_reg[ST];
    assign out_x     = x_reg[ST];
    assign out_y     = y_reg[ST];
    assign out_flip  = flip_reg[ST];

endmodule

[src/gtec_mul_step.sv]
`timescale 1ns / 1ps

module gtec_mul_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  gtec_pkg::job_t       job_in,
    input  logic [63:0]          a,
    input  logic [63:0]          b,
    output gtec_pkg::job_t       job_out,
    output logic [127:0]         prod
);
    import gtec_pkg::*;

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    job_t         job1_reg, job2_reg;
    logic         valid1_reg, valid2_reg;
    logic [127:0] prod_reg, prod_next;

    // partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
            lh_reg <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
            hl_reg <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            hh_reg <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
            job1_reg <= job_in;
            job2_reg <= job1_reg;
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= job_in.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_comb begin
        prod_next = {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                  + {hh_reg, 64'd0};
    end

    always_comb begin
        job_out = job2_reg;
        job_out.valid = valid2_reg;
    end

    assign prod = prod_reg;

endmodule

[src/geodetic_to_ecef_converter.sv]
`timescale 1ns / 1ps
// channel   dir  ports                      tdata fields (low bit up)
// s_        in   s_tvalid s_tready s_tdata  latitude_angle, longitude_angle, height_mm
// m_        out  m_tvalid m_tready m_tdata  ecef_x_mm, ecef_y_mm, ecef_z_mm
//
// one request per cycle while the pipeline is not held; the path runs through
// the sine/cosine stages, then the 44 multiply steps
// (36 of them in the inverse square root), then the output register
// aresetn clears all valid bits; no clearing pass
// the whole pipeline holds while a result waits and m_tready is low
`include "geodetic_to_ecef_converter_assert.svh"

module geodetic_to_ecef_converter (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // latitude_angle, longitude_angle, height_mm
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata    // ecef_x_mm, ecef_y_mm, ecef_z_mm
);
    import gtec_pkg::*;

    logic adv;

    logic               lat_valid, lon_valid;
    logic signed [63:0] lat_x, lat_y, lon_x, lon_y;
    logic               lat_flip, lon_flip;
    logic signed [63:0] h_reg [0:ST];

    job_t         job_s [0:NSTEP];
    job_t         job_o [0:NSTEP-1];
    logic [63:0]  a_s [0:NSTEP-1];
    logic [63:0]  b_s [0:NSTEP-1];
    logic [127:0] prod_s [0:NSTEP-1];

    logic         m_valid_reg;
    logic [103:0] m_data_reg;

    logic signed [33:0] out_x;
    logic               x_in_range;

    assign adv = !m_valid_reg || m_tready;
    assign s_tready = adv;

    gtec_cordic u_lat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .angle     (signed'(s_tdata[31:0])),
        .out_valid (lat_valid),
        .out_x     (lat_x),
        .out_y     (lat_y),
        .out_flip  (lat_flip)
    );

    gtec_cordic u_lon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .angle     (signed'(s_tdata[63:32])),
        .out_valid (lon_valid),
        .out_x     (lon_x),
        .out_y     (lon_y),
        .out_flip  (lon_flip)
    );

    // height rides beside the cordic stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            h_reg[0] <= {{16{s_tdata[91]}}, s_tdata[91:64], 20'd0};
            for (int i = 0; i < ST; i++) begin
                h_reg[i+1] <= h_reg[i];
            end
        end
    end

    always_comb begin
        job_s[0] = '0;
        job_s[0].valid = lat_valid;
        job_s[0].slat  = lat_flip ? -lat_y : lat_y;
        job_s[0].clat  = lat_flip ? -lat_x : lat_x;
        job_s[0].slon  = lon_flip ? -lon_y : lon_y;
        job_s[0].clon  = lon_flip ? -lon_x : lon_x;
        job_s[0].h     = h_reg[ST];
    end

    for (genvar g = 0; g < NSTEP; g++) begin : g_step
        localparam step_kind_t KIND = step_kind(g);

        assign a_s[g] = op_a(KIND, job_s[g]);
        assign b_s[g] = op_b(KIND, job_s[g]);

        gtec_mul_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .job_in  (job_s[g]),
            .a       (a_s[g]),
            .b       (b_s[g]),
            .job_out (job_o[g]),
            .prod    (prod_s[g])
        );

        assign job_s[g+1] = post(KIND, job_o[g], prod_s[g]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= job_s[NSTEP].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {2'b00, finish(job_s[NSTEP].z), finish(job_s[NSTEP].y),
                           finish(job_s[NSTEP].x)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign out_x      = signed'(m_tdata[33:0]);
    assign x_in_range = (out_x <= 34'sd6500000000) && (out_x >= -34'sd6500000000);

    `GTEC_ASSERT_NORST(a_reset_clears, aclk, !aresetn |=> !m_tvalid)
    `GTEC_ASSERT(a_x_saturated, aclk, aresetn, m_tvalid |-> x_in_range)
    `GTEC_ASSERT(a_stall_holds, aclk, aresetn, !adv |=> $stable(job_s[NSTEP].valid))
    `GTEC_ASSERT(a_lanes_aligned, aclk, aresetn, lat_valid == lon_valid)

endmodule
